// ===== rtl/mbwf_pkg.sv =====
// Package for the Modbus function-16 frame builder: payload types, queue entry,
// frame byte indexes and protocol constants. No dependencies.
`default_nettype none
package mbwf_pkg;

  localparam int unsigned MAX_WORDS = 5;
  localparam int unsigned QDEPTH    = 2;
  localparam int unsigned QADDR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [15:0] CRC_PRESET       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY         = 16'hA001;
  localparam logic [7:0]  FUNC_WRITE_MULTI = 8'h10;
  localparam logic [7:0]  REGS_PER_WORD    = 8'h02;

  // Byte positions within one frame.
  localparam logic [3:0] IDX_STATION  = 4'd0;
  localparam logic [3:0] IDX_FUNC     = 4'd1;
  localparam logic [3:0] IDX_ADDR_HI  = 4'd2;
  localparam logic [3:0] IDX_ADDR_LO  = 4'd3;
  localparam logic [3:0] IDX_REGS_HI  = 4'd4;
  localparam logic [3:0] IDX_REGS_LO  = 4'd5;
  localparam logic [3:0] IDX_BYTES    = 4'd6;
  localparam logic [3:0] IDX_DATA_3   = 4'd7;
  localparam logic [3:0] IDX_DATA_2   = 4'd8;
  localparam logic [3:0] IDX_DATA_1   = 4'd9;
  localparam logic [3:0] IDX_DATA_0   = 4'd10;
  localparam logic [3:0] IDX_CRC_LO   = 4'd11;
  localparam logic [3:0] IDX_CRC_HI   = 4'd12;

  typedef struct packed {
    logic [7:0]  station;
    logic [15:0] start_register;
    logic [2:0]  word_count;
    logic [31:0] data_word;
  } mbwf_in_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } mbwf_out_t;

  // One classified word on its way to the serializer.
  typedef struct packed {
    logic        first;
    logic        last;
    logic [7:0]  station;
    logic [15:0] start_register;
    logic [2:0]  words;
    logic [31:0] data_word;
  } mbwf_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/mbwf_front.sv =====
// Front end of the frame builder: accepts words, tracks the open frame and
// classifies each word as first / last. Depends on mbwf_pkg.
`default_nettype none
module mbwf_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire mbwf_pkg::mbwf_in_t in_data,
  output logic                   push_valid,
  input  wire logic              push_ready,
  output mbwf_pkg::mbwf_cmd_t    push_cmd
);

  localparam logic [2:0] MAX_N = 3'(mbwf_pkg::MAX_WORDS);

  logic [2:0] words_left_r, words_left_nxt;
  logic [2:0] n_sat;
  logic       open_frame;
  logic       accept;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;
  assign open_frame = (words_left_r != 3'd0);

  always_comb begin
    // Saturate the count: zero counts as one, clamp above the maximum.
    if (in_data.word_count == 3'd0) begin
      n_sat = 3'd1;
    end else if (in_data.word_count > MAX_N) begin
      n_sat = MAX_N;
    end else begin
      n_sat = in_data.word_count;
    end
  end

  always_comb begin
    push_cmd.station        = in_data.station;
    push_cmd.start_register = in_data.start_register;
    push_cmd.data_word      = in_data.data_word;
    push_cmd.words          = n_sat;
    push_cmd.first          = !open_frame;
    if (open_frame) begin
      push_cmd.last  = (words_left_r == 3'd1);
      words_left_nxt = words_left_r - 3'd1;
    end else begin
      push_cmd.last  = (n_sat == 3'd1);
      words_left_nxt = n_sat - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_left_r <= 3'd0;
    end else if (accept) begin
      words_left_r <= words_left_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mbwf_queue.sv =====
// Short queue between front and back ends of the frame builder.
// Register array of mbwf_pkg::QDEPTH entries; depends on mbwf_pkg.
`default_nettype none
module mbwf_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push_valid,
  output logic                     push_ready,
  input  wire mbwf_pkg::mbwf_cmd_t push_cmd,
  output logic                     pop_valid,
  input  wire logic                pop_ready,
  output mbwf_pkg::mbwf_cmd_t      pop_cmd
);

  localparam logic [mbwf_pkg::QCNT_W-1:0] DEPTH = mbwf_pkg::QCNT_W'(mbwf_pkg::QDEPTH);

  mbwf_pkg::mbwf_cmd_t             mem_r [mbwf_pkg::QDEPTH];
  logic [mbwf_pkg::QADDR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [mbwf_pkg::QCNT_W-1:0]     cnt_r;
  logic                            push, pop;

  assign push_ready = (cnt_r != DEPTH);
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= DEPTH)
    else $error("queue count above depth");
  a_cnt_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count missed a push");
  a_cnt_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (cnt_r == $past(cnt_r) - 1'b1))
    else $error("queue count missed a pop");

endmodule
`default_nettype wire

// ===== rtl/mbwf_back.sv =====
// Back end of the frame builder: serializes queued words into frame bytes,
// runs the CRC-16/Modbus one byte per cycle while a word waits and the output
// is not stalled, drives the output register. Depends on mbwf_pkg.
`default_nettype none
module mbwf_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                head_valid,
  output logic                     head_pop,
  input  wire mbwf_pkg::mbwf_cmd_t head_cmd,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output mbwf_pkg::mbwf_out_t      out_data
);

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ mbwf_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  logic                busy_r, busy_nxt;
  logic [3:0]          idx_r, idx_nxt;
  logic [15:0]         crc_r, crc_nxt;
  logic                out_valid_r, out_valid_nxt;
  mbwf_pkg::mbwf_out_t out_data_r;
  logic [3:0]          cur_idx, end_idx;
  logic [7:0]          cur_byte;
  logic [15:0]         regs16, crc_base;
  logic                step, final_byte;

  assign step     = head_valid && (!out_valid_r || out_ready);
  assign cur_idx  = busy_r ? idx_r
                  : (head_cmd.first ? mbwf_pkg::IDX_STATION : mbwf_pkg::IDX_DATA_3);
  assign end_idx  = head_cmd.last ? mbwf_pkg::IDX_CRC_HI : mbwf_pkg::IDX_DATA_0;
  assign final_byte = (cur_idx == end_idx);
  assign head_pop = step && final_byte;
  assign regs16   = 16'(head_cmd.words) * 16'(mbwf_pkg::REGS_PER_WORD);
  assign crc_base = (cur_idx == mbwf_pkg::IDX_STATION) ? mbwf_pkg::CRC_PRESET : crc_r;

  always_comb begin
    case (cur_idx)
      mbwf_pkg::IDX_STATION: cur_byte = head_cmd.station;
      mbwf_pkg::IDX_FUNC:    cur_byte = mbwf_pkg::FUNC_WRITE_MULTI;
      mbwf_pkg::IDX_ADDR_HI: cur_byte = head_cmd.start_register[15:8];
      mbwf_pkg::IDX_ADDR_LO: cur_byte = head_cmd.start_register[7:0];
      mbwf_pkg::IDX_REGS_HI: cur_byte = regs16[15:8];
      mbwf_pkg::IDX_REGS_LO: cur_byte = regs16[7:0];
      mbwf_pkg::IDX_BYTES:   cur_byte = 8'({head_cmd.words, 2'b00});
      mbwf_pkg::IDX_DATA_3:  cur_byte = head_cmd.data_word[31:24];
      mbwf_pkg::IDX_DATA_2:  cur_byte = head_cmd.data_word[23:16];
      mbwf_pkg::IDX_DATA_1:  cur_byte = head_cmd.data_word[15:8];
      mbwf_pkg::IDX_DATA_0:  cur_byte = head_cmd.data_word[7:0];
      mbwf_pkg::IDX_CRC_LO:  cur_byte = crc_r[7:0];
      mbwf_pkg::IDX_CRC_HI:  cur_byte = crc_r[15:8];
      default:               cur_byte = 8'h00;
    endcase
  end

  always_comb begin
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (step) begin
      out_valid_nxt = 1'b1;
      busy_nxt      = !final_byte;
      idx_nxt       = cur_idx + 4'd1;
      // Fold header and data bytes into the CRC; hold it over the CRC bytes.
      if (cur_idx <= mbwf_pkg::IDX_DATA_0) begin
        crc_nxt = crc_byte(crc_base, cur_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= mbwf_pkg::IDX_STATION;
      crc_r       <= mbwf_pkg::CRC_PRESET;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r.frame_byte <= cur_byte;
      out_data_r.frame_end  <= (cur_idx == mbwf_pkg::IDX_CRC_HI);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r >= mbwf_pkg::IDX_FUNC && idx_r <= mbwf_pkg::IDX_CRC_HI))
    else $error("byte index out of frame");
  a_crc_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (step && cur_idx >= mbwf_pkg::IDX_CRC_LO) |-> head_cmd.last)
    else $error("crc byte on a word that does not close the frame");
  a_end_pops: assert property (@(posedge clk) disable iff (!rst_n)
    (step && cur_idx == mbwf_pkg::IDX_CRC_HI) |=> (out_data.frame_end && !busy_r))
    else $error("frame end not marked or serializer still busy");

endmodule
`default_nettype wire

// ===== rtl/modbus_write_multiple_frame_builder_unit.sv =====
// Top level of the Modbus RTU function-16 request frame builder.
// Instantiates mbwf_front, mbwf_queue and mbwf_back; depends on mbwf_pkg.
//
// Usage:
//   in_*  : one 32-bit data word per transfer. On the first word of a frame
//           station, start_register and word_count are taken as well; word
//           count zero counts as one, counts above MAX_WORDS are clamped.
//   out_* : one frame byte per transfer; frame_end marks the CRC high byte.
//   A frame is station, 0x10, address hi/lo, register count hi/lo, byte
//   count, four big-endian bytes per word, then the CRC-16/Modbus low/high.
// Throughput: the serializer emits one byte per cycle while the receiver
//   does not stall; a word runs from the station byte (first word) or its
//   first data byte through its last data byte, or the CRC high byte when it
//   closes the frame. A word's first byte passes the queue and the output register.
// The front end keeps accepting into a two-entry queue while the back end
//   works; when the receiver stalls, the output byte holds and in_ready
//   drops once the queue is full.
// Reset: queue empty, no frame open, CRC at its preset.
`default_nettype none
module modbus_write_multiple_frame_builder_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire mbwf_pkg::mbwf_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output mbwf_pkg::mbwf_out_t      out_data
);

  logic                push_valid, push_ready;
  mbwf_pkg::mbwf_cmd_t push_cmd;
  logic                head_valid, head_pop;
  mbwf_pkg::mbwf_cmd_t head_cmd;

  // Classify words and track the open frame.
  mbwf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // Decouple the front from the byte serializer.
  mbwf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (head_valid),
    .pop_ready  (head_pop),
    .pop_cmd    (head_cmd)
  );

  // Serialize bytes, run the CRC, drive the output register.
  mbwf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .head_cmd   (head_cmd),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for modbus_write_multiple_frame_builder_unit: directed
// frames, then random frames, each checked byte by byte against a frame predictor.
// Depends on mbwf_pkg and the frame builder RTL.
`timescale 1ns / 1ps
module tb;

  localparam int unsigned IDLE_LIMIT  = 5000;  // cycles with no transfer at all
  localparam int unsigned LONG_HOLD   = 300;   // receiver hold-off that fills the block
  localparam int unsigned HOLD_AFTER  = 60;    // words taken before the long hold
  localparam int unsigned RAND_WORDS  = 130;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned MAX_REPORTS = 10;

  // One row of the directed table. Rows that open a frame carry the seven
  // header bytes typed in, since they read straight off the field values.
  typedef struct packed {
    mbwf_pkg::mbwf_in_t item;
    logic               typed;
    logic [55:0]        hdr;
  } plan_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  mbwf_pkg::mbwf_in_t  in_data;
  logic                out_valid;
  logic                out_ready;
  mbwf_pkg::mbwf_out_t out_data;

  // Predictor state: CRC of the open frame and words still owed to it.
  logic [15:0] crc_acc;
  logic [2:0]  words_open;

  mbwf_pkg::mbwf_out_t pending_bytes [$];  // expected frame bytes, oldest first
  plan_row_t           hdr_notes [$];      // typed header per offered word, in offer order
  plan_row_t           plan [$];

  int unsigned mismatch_cnt;
  int unsigned words_taken;
  int unsigned idle_cycles;
  logic        long_hold_done;

  modbus_write_multiple_frame_builder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Fold one byte into the CRC-16/Modbus (reflected, LSB first).
  function automatic logic [15:0] crc_fold(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ mbwf_pkg::CRC_POLY) : (r >> 1);
    return r;
  endfunction

  // Work out every byte one accepted word causes and queue them. A typed
  // header replaces the computed one in the expectation only; the CRC always
  // runs over the computed bytes.
  function automatic void predict_frame_bytes(input mbwf_pkg::mbwf_in_t it,
                                              input plan_row_t note);
    logic [2:0]  n;
    logic [15:0] regs;
    logic [55:0] hdr_calc;
    logic [55:0] hdr_exp;
    if (words_open == 3'd0) begin
      // Take a zero count as one and clamp anything above the frame limit.
      n = (it.word_count == 3'd0) ? 3'd1 : it.word_count;
      if (n > mbwf_pkg::MAX_WORDS) n = 3'(mbwf_pkg::MAX_WORDS);
      regs = 16'(mbwf_pkg::REGS_PER_WORD) * 16'(n);
      hdr_calc = {it.station, mbwf_pkg::FUNC_WRITE_MULTI, it.start_register, regs,
                  8'(n) * 8'd4};
      hdr_exp = note.typed ? note.hdr : hdr_calc;
      crc_acc = mbwf_pkg::CRC_PRESET;
      for (int i = 6; i >= 0; i--) begin
        crc_acc = crc_fold(crc_acc, hdr_calc[8*i +: 8]);
        pending_bytes.push_back('{frame_byte: hdr_exp[8*i +: 8], frame_end: 1'b0});
      end
      words_open = n;
    end
    for (int i = 3; i >= 0; i--) begin
      crc_acc = crc_fold(crc_acc, it.data_word[8*i +: 8]);
      pending_bytes.push_back('{frame_byte: it.data_word[8*i +: 8], frame_end: 1'b0});
    end
    words_open = words_open - 3'd1;
    if (words_open == 3'd0) begin
      pending_bytes.push_back('{frame_byte: crc_acc[7:0], frame_end: 1'b0});
      pending_bytes.push_back('{frame_byte: crc_acc[15:8], frame_end: 1'b1});
      crc_acc = mbwf_pkg::CRC_PRESET;
    end
  endfunction

  function automatic plan_row_t row(input logic [7:0] st, input logic [15:0] reg_addr,
                                    input logic [2:0] cnt, input logic [31:0] word,
                                    input logic typed, input logic [55:0] hdr);
    plan_row_t r;
    r.item.station        = st;
    r.item.start_register = reg_addr;
    r.item.word_count     = cnt;
    r.item.data_word      = word;
    r.typed               = typed;
    r.hdr                 = hdr;
    return r;
  endfunction

  // Gap length: drawn from three bands, short ones most often, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offer one word and hold it until the transfer. In a burst, skip the gap.
  task automatic offer_word(input plan_row_t r, input logic burst);
    int gap;
    gap = (burst || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    hdr_notes.push_back(r);
    in_valid <= 1'b1;
    in_data  <= r.item;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and hold off until every expected byte has come out. Wait on the
  // clock first so the last transfer's bytes are already predicted.
  task automatic drain_frames();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
  endtask

  // Check first, then predict: a word's own bytes never come out at the
  // edge of its transfer, so the order cannot hide a stray byte.
  always @(posedge clk) begin
    mbwf_pkg::mbwf_out_t exp_b;
    plan_row_t           note;
    if (rst_n && out_valid && out_ready) begin
      if (pending_bytes.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("%0t: unexpected frame byte %02h end %b", $realtime,
                   out_data.frame_byte, out_data.frame_end);
      end else begin
        exp_b = pending_bytes.pop_front();
        if (out_data.frame_byte !== exp_b.frame_byte) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("%0t: frame_byte expected %02h actual %02h", $realtime,
                     exp_b.frame_byte, out_data.frame_byte);
        end
        if (out_data.frame_end !== exp_b.frame_end) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("%0t: frame_end expected %b actual %b (byte %02h)", $realtime,
                     exp_b.frame_end, out_data.frame_end, exp_b.frame_byte);
        end
      end
    end
    if (rst_n && in_valid && in_ready) begin
      note = hdr_notes.pop_front();
      predict_frame_bytes(in_data, note);
      words_taken++;
    end
  end

  // Watchdog: end the run if neither channel moves a transfer for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stalls, calm stretches with no stall, and one long
  // hold-off so the queue fills and in_ready drops.
  initial begin : rx_side
    int stall;
    int calm;
    stall = 0;
    calm  = 0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!long_hold_done && words_taken >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        stall = LONG_HOLD;
      end else if (stall == 0 && calm == 0) begin
        if ($urandom_range(0, 19) == 0) calm = $urandom_range(20, 60);
        else if ($urandom_range(0, 4) == 0) stall = pick_gap();
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        if (calm > 0) calm--;
      end
    end
  end

  initial begin : tx_side
    logic [2:0]  cnt;
    logic [2:0]  n;
    logic        burst;
    int unsigned frames;
    plan_row_t   r;

    crc_acc        = mbwf_pkg::CRC_PRESET;
    words_open     = 3'd0;
    mismatch_cnt   = 0;
    words_taken    = 0;
    idle_cycles    = 0;
    long_hold_done = 1'b0;
    frames         = 0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;

    // Directed frames: field extremes, zero and oversized counts, every
    // frame length, and junk header fields on later words.
    plan.push_back(row(8'h01, 16'h0000, 3'd1, 32'h0000_0000, 1'b1, 56'h01_10_0000_0002_04));
    plan.push_back(row(8'hFF, 16'hFFFF, 3'd0, 32'hFFFF_FFFF, 1'b1, 56'hFF_10_FFFF_0002_04));
    plan.push_back(row(8'hA5, 16'h1234, 3'd7, 32'h1234_5678, 1'b1, 56'hA5_10_1234_000A_14));
    plan.push_back(row(8'hFF, 16'hFFFF, 3'd1, 32'hDEAD_BEEF, 1'b0, '0));
    plan.push_back(row(8'h00, 16'h0000, 3'd0, 32'h0000_0001, 1'b0, '0));
    plan.push_back(row(8'h3C, 16'hA5A5, 3'd7, 32'h8000_0000, 1'b0, '0));
    plan.push_back(row(8'hC3, 16'h5A5A, 3'd2, 32'hFFFF_FFFF, 1'b0, '0));
    plan.push_back(row(8'h00, 16'h8000, 3'd5, 32'h8000_0001, 1'b1, 56'h00_10_8000_000A_14));
    plan.push_back(row(8'h11, 16'h2222, 3'd3, 32'h0102_0304, 1'b0, '0));
    plan.push_back(row(8'h44, 16'h5555, 3'd6, 32'hA0B0_C0D0, 1'b0, '0));
    plan.push_back(row(8'h77, 16'h8888, 3'd4, 32'h0000_FFFF, 1'b0, '0));
    plan.push_back(row(8'h99, 16'hAAAA, 3'd5, 32'hFFFF_0000, 1'b0, '0));
    plan.push_back(row(8'h5A, 16'h00FF, 3'd2, 32'h7FFF_FFFF, 1'b1, 56'h5A_10_00FF_0004_08));
    plan.push_back(row(8'hFF, 16'hFFFF, 3'd7, 32'h5555_AAAA, 1'b0, '0));
    plan.push_back(row(8'h80, 16'h7F00, 3'd3, 32'hCAFE_F00D, 1'b1, 56'h80_10_7F00_0006_0C));
    plan.push_back(row(8'h01, 16'h0001, 3'd1, 32'h1111_1111, 1'b0, '0));
    plan.push_back(row(8'hFE, 16'hFFFE, 3'd0, 32'hEEEE_EEEE, 1'b0, '0));
    plan.push_back(row(8'h7F, 16'h0001, 3'd4, 32'h0F0F_0F0F, 1'b1, 56'h7F_10_0001_0008_10));
    plan.push_back(row(8'h00, 16'h0000, 3'd0, 32'hF0F0_F0F0, 1'b0, '0));
    plan.push_back(row(8'hFF, 16'hFFFF, 3'd7, 32'h0000_0000, 1'b0, '0));
    plan.push_back(row(8'h12, 16'h3456, 3'd1, 32'hFFFF_FFFF, 1'b0, '0));

    // Hold reset low, then release it for good.
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) offer_word(plan[i], 1'b0);

    // Pause the sender until the directed frames are fully out.
    drain_frames();

    // Random frames: mostly legal counts, sometimes zero or oversized,
    // with random junk in the header fields of later words.
    while (words_taken < plan.size() + RAND_WORDS) begin
      burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0)
        cnt = ($urandom_range(0, 2) == 0) ? 3'd0 : 3'($urandom_range(6, 7));
      else
        cnt = 3'($urandom_range(1, mbwf_pkg::MAX_WORDS));
      n = (cnt == 3'd0) ? 3'd1
        : ((cnt > mbwf_pkg::MAX_WORDS) ? 3'(mbwf_pkg::MAX_WORDS) : cnt);
      for (int w = 0; w < n; w++) begin
        r.item.station        = 8'($urandom);
        r.item.start_register = 16'($urandom);
        r.item.word_count     = (w == 0) ? cnt : 3'($urandom);
        r.item.data_word      = $urandom;
        r.typed               = 1'b0;
        r.hdr                 = '0;
        offer_word(r, burst);
      end
      frames++;
      // Once, after the eighth random frame, let the block run dry.
      if (frames == 8) drain_frames();
    end

    // Drop valid, wait out the remaining bytes, then wait DRAIN_CYCLES more.
    drain_frames();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_bytes.size() != 0 || words_open != 3'd0) mismatch_cnt++;
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
